// ----- design/tccw_pkg.sv -----
// ---------------------------------------------------------------------------
// tccw_pkg: shared types and constants of the text console cursor writer
// Field widths, request codes, control characters and controller states.
// ---------------------------------------------------------------------------
package tccw_pkg;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = ATTR_W + CHAR_W;

   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   typedef enum logic [1:0] {
      REQ_PUT_CHAR   = 2'd0,
      REQ_READ_CELL  = 2'd1,
      REQ_CLEAR      = 2'd2,
      REQ_SET_CURSOR = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } state_type;

endpackage

// ----- design/tccw_ram.sv -----
// ---------------------------------------------------------------------------
// tccw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ---------------------------------------------------------------------------
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/text_console_cursor_writer.sv -----
// ---------------------------------------------------------------------------
// text_console_cursor_writer: text-mode console with cursor and screen store
// Keeps ROWS x COLUMNS cells (attribute high byte, character low byte) in a
// RAM, scrolls through a rotating top-row offset and blanks rows by walks.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              word
//  req_      in         req_valid / req_stall  type, char code, row, col
//  rsp_      out        rsp_valid / rsp_stall  cell data, cursor, scrolled
//  csr_      in         csr_wr_en              colour attribute byte
//
//  Put character, clear and set cursor respond from the idle state; read cell
//  goes through ST_READ to wait for the registered RAM read.
//  A scroll walks the COLUMNS cells of a row, a clear all ROWS*COLUMNS cells,
//  through the single RAM write port; no word is taken during a walk.
//  After reset the same walk over all ROWS*COLUMNS cells blanks the screen.
//  A stalled response holds; the next word is taken in the cycle it drains.
//
module text_console_cursor_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tccw_pkg::ROW_W-1:0]    req_row,
   input  logic [tccw_pkg::COL_W-1:0]    req_col,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tccw_pkg::CELL_W-1:0]   rsp_cell_data,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tccw_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic                          rsp_scrolled,
   input  logic                          csr_wr_en,
   input  logic [tccw_pkg::ATTR_W-1:0]   csr_wr_data
);

   import tccw_pkg::*;

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   state_type          state_ff, state_in;
   logic [ATTR_W-1:0]  attr_ff;
   logic [ATTR_W-1:0]  walk_attr_ff, walk_attr_in;
   logic [AW-1:0]      walk_cnt_ff, walk_cnt_in;
   logic [COL_W-1:0]   walk_col_ff, walk_col_in;
   logic [AW-1:0]      scroll_base_ff, scroll_base_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic               rsp_scr_ff, rsp_scr_in;

   logic               accept;
   req_code_type       code;
   logic [ROW_W-1:0]   sat_row;
   logic [COL_W-1:0]   sat_col;

   // put-character datapath
   logic [COL_W:0]     pc_col;
   logic [ROW_W:0]     pc_row;
   logic               pc_we;
   logic [COL_W-1:0]   pc_wcol;
   logic [CHAR_W-1:0]  pc_char;
   logic               pc_scroll;

   // address generation
   logic [ROW_W-1:0]   a_row;
   logic [COL_W-1:0]   a_col;
   logic [ROW_W:0]     phys_sum;
   logic [ROW_W-1:0]   phys_row;
   logic [AW-1:0]      cell_addr;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic [CELL_W-1:0]  ram_rdata;

   assign code    = req_code_type'(req_type);
   assign accept  = req_valid && !req_stall;
   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));

   assign sat_row = (req_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : req_row;
   assign sat_col = (req_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : req_col;

   // cursor update for one put-character word
   always_comb begin
      pc_col    = {1'b0, cur_col_ff};
      pc_row    = {1'b0, cur_row_ff};
      pc_we     = 1'b0;
      pc_wcol   = cur_col_ff;
      pc_char   = req_char_code;
      pc_scroll = 1'b0;
      case (req_char_code)
         CH_NEWLINE: begin
            pc_col = '0;
            pc_row = pc_row + 1'b1;
         end
         CH_RETURN: begin
            pc_col = '0;
         end
         CH_BACKSPACE: begin
            if (cur_col_ff != '0) begin
               pc_col  = pc_col - 1'b1;
               pc_wcol = cur_col_ff - 1'b1;
               pc_we   = 1'b1;
               pc_char = CH_SPACE;
            end
         end
         CH_TAB: begin
            pc_col = (pc_col + (COL_W + 1)'(8)) & ~(COL_W + 1)'(7);
         end
         default: begin
            pc_we  = 1'b1;
            pc_col = pc_col + 1'b1;
         end
      endcase
      if (pc_col >= (COL_W + 1)'(COLUMNS)) begin
         pc_col = '0;
         pc_row = pc_row + 1'b1;
      end
      if (pc_row >= (ROW_W + 1)'(ROWS)) begin
         pc_row    = (ROW_W + 1)'(ROWS - 1);
         pc_scroll = 1'b1;
      end
   end

   // screen row to physical RAM address through the top-row offset
   always_comb begin
      if (code == REQ_READ_CELL) begin
         a_row = sat_row;
         a_col = sat_col;
      end else begin
         a_row = cur_row_ff;
         a_col = pc_wcol;
      end
      phys_sum = {1'b0, top_ff} + {1'b0, a_row};
      if (phys_sum >= (ROW_W + 1)'(ROWS)) begin
         phys_sum = phys_sum - (ROW_W + 1)'(ROWS);
      end
      phys_row  = phys_sum[ROW_W-1:0];
      cell_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(a_col);
   end

   always_comb begin
      state_in       = state_ff;
      walk_attr_in   = walk_attr_ff;
      walk_cnt_in    = walk_cnt_ff;
      walk_col_in    = walk_col_ff;
      scroll_base_in = scroll_base_ff;
      top_in         = top_ff;
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_scr_in     = rsp_scr_ff;
      ram_we         = 1'b0;
      ram_waddr      = cell_addr;
      ram_wdata      = {attr_ff, pc_char};

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = walk_cnt_ff;
            ram_wdata = {walk_attr_ff, CH_SPACE};
            walk_cnt_in = walk_cnt_ff + 1'b1;
            if (walk_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            ram_we    = 1'b1;
            ram_waddr = scroll_base_ff + AW'(walk_col_ff);
            ram_wdata = {walk_attr_ff, CH_SPACE};
            walk_col_in = walk_col_ff + 1'b1;
            if (walk_col_ff == COL_W'(COLUMNS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = ram_rdata;
            rsp_row_in   = cur_row_ff;
            rsp_col_in   = cur_col_ff;
            rsp_scr_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in = '0;
               rsp_scr_in  = 1'b0;
               case (code)
                  REQ_PUT_CHAR: begin
                     ram_we     = pc_we;
                     cur_row_in = pc_row[ROW_W-1:0];
                     cur_col_in = pc_col[COL_W-1:0];
                     rsp_scr_in = pc_scroll;
                     if (pc_scroll) begin
                        // the row leaving the top becomes the new bottom row
                        scroll_base_in = AW'(top_ff) * AW'(COLUMNS);
                        top_in = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                        walk_col_in  = '0;
                        walk_attr_in = attr_ff;
                        state_in     = ST_SCROLL;
                     end
                  end
                  REQ_READ_CELL: begin
                     state_in = ST_READ;
                  end
                  REQ_CLEAR: begin
                     top_in       = '0;
                     cur_row_in   = '0;
                     cur_col_in   = '0;
                     walk_cnt_in  = '0;
                     walk_attr_in = attr_ff;
                     state_in     = ST_CLEAR;
                  end
                  REQ_SET_CURSOR: begin
                     cur_row_in = sat_row;
                     cur_col_in = sat_col;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
               if (code != REQ_READ_CELL) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = cur_row_in;
                  rsp_col_in   = cur_col_in;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         attr_ff      <= ATTR_RESET;
         walk_attr_ff <= ATTR_RESET;
         walk_cnt_ff  <= '0;
         walk_col_ff  <= '0;
         top_ff       <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_attr_ff <= walk_attr_in;
         walk_cnt_ff  <= walk_cnt_in;
         walk_col_ff  <= walk_col_in;
         top_ff       <= top_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scroll_base_ff <= scroll_base_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_scr_ff     <= rsp_scr_in;
   end

   tccw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(DEPTH)
   ) u_screen_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(cell_addr),
      .rd_data(ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff < ROW_W'(ROWS)) && (cur_col_ff < COL_W'(COLUMNS)))
      else $error("cursor outside the screen");

   a_top_in_range: assert property (@(posedge clock) disable iff (reset)
      top_ff < ROW_W'(ROWS))
      else $error("top-row offset out of range");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("read data returned with the response register occupied");

   a_scroll_bottom: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scr_ff) |-> (rsp_row_ff == ROW_W'(ROWS - 1)))
      else $error("scroll reported off the last row");

   a_scroll_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && accept && code == REQ_PUT_CHAR && pc_scroll)
         |=> (state_ff == ST_SCROLL && walk_col_ff == '0))
      else $error("scroll did not start a row blanking walk");

endmodule

// ----- test/tb_text_console_cursor_writer.sv -----
// ---------------------------------------------------------------------------
// tb_text_console_cursor_writer: self-checking bench for the text console
// A queued driver feeds put-char, read, clear and set-cursor words while a
// monitor checks every response against an in-bench model of the screen,
// cursor and scroll offset, across several attribute settings and stall mixes.
// ---------------------------------------------------------------------------
module tb_text_console_cursor_writer;
   import tccw_pkg::*;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int WALK_WAIT  = ROWS * COLUMNS + 100;
   localparam int QUIET_MAX  = 20000;
   localparam int LONG_HOLD  = 300;
   localparam int PHASE_WORDS = 245;

   typedef struct packed {
      req_code_type         kind;
      logic [CHAR_W-1:0]    char_code;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
   } console_req_type;

   typedef struct packed {
      logic [CELL_W-1:0]    cell_val;
      logic [ROW_W-1:0]     crow;
      logic [COL_W-1:0]     ccol;
      logic                 scrolled;
   } console_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CELL_W-1:0]   rsp_cell_data;
   logic [ROW_W-1:0]    rsp_cursor_row;
   logic [COL_W-1:0]    rsp_cursor_col;
   logic                rsp_scrolled;
   logic                csr_wr_en = 1'b0;
   logic [ATTR_W-1:0]   csr_wr_data = '0;
   console_req_type     cur_req = '0;

   console_req_type     pending_reqs[$];
   console_rsp_type     expected_rsps[$];

   // screen model
   logic [CELL_W-1:0]   screen_model [0:ROWS*COLUMNS-1];
   int unsigned         top_model;
   int unsigned         row_model;
   int unsigned         col_model;
   logic [ATTR_W-1:0]   attr_model;

   int unsigned         send_idle_pct = 24;
   int unsigned         recv_idle_pct = 69;
   int unsigned         hold_trig = 0;
   int unsigned         hold_seen = 0;
   int unsigned         hold_left = 0;
   int unsigned         fail_count = 0;
   int unsigned         quiet_cycles = 0;

   always #4 clock = ~clock;

   text_console_cursor_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (cur_req.kind),
      .req_char_code  (cur_req.char_code),
      .req_row        (cur_req.row),
      .req_col        (cur_req.col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_scrolled   (rsp_scrolled),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
      int unsigned p;
      p = top_model + r;
      if (p >= ROWS) p -= ROWS;
      return p * COLUMNS + c;
   endfunction

   function automatic logic [CELL_W-1:0] blank_cell();
      return {attr_model, CH_SPACE};
   endfunction

   function automatic void blank_screen();
      for (int i = 0; i < ROWS * COLUMNS; i++) screen_model[i] = blank_cell();
      top_model = 0;
      row_model = 0;
      col_model = 0;
   endfunction

   // returns 1 when the character pushed the cursor off the bottom
   function automatic logic place_char(logic [CHAR_W-1:0] ch);
      case (ch)
         CH_NEWLINE: begin
            col_model = 0;
            row_model++;
         end
         CH_RETURN: col_model = 0;
         CH_BACKSPACE: begin
            if (col_model > 0) begin
               col_model--;
               screen_model[cell_addr(row_model, col_model)] = blank_cell();
            end
         end
         CH_TAB: col_model = (col_model + 8) & ~32'd7;
         default: begin
            screen_model[cell_addr(row_model, col_model)] = {attr_model, ch};
            col_model++;
         end
      endcase
      if (col_model >= COLUMNS) begin
         col_model = 0;
         row_model++;
      end
      if (row_model >= ROWS) begin
         top_model = (top_model + 1) % ROWS;
         for (int c = 0; c < COLUMNS; c++) screen_model[cell_addr(ROWS - 1, c)] = blank_cell();
         row_model = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic console_rsp_type console_apply(console_req_type rq);
      console_rsp_type res;
      int unsigned     r;
      int unsigned     c;
      res = '0;
      r = (rq.row > ROWS - 1) ? ROWS - 1 : rq.row;
      c = (rq.col > COLUMNS - 1) ? COLUMNS - 1 : rq.col;
      case (rq.kind)
         REQ_PUT_CHAR:  res.scrolled = place_char(rq.char_code);
         REQ_READ_CELL: res.cell_val = screen_model[cell_addr(r, c)];
         REQ_CLEAR:     blank_screen();
         default: begin
            row_model = r;
            col_model = c;
         end
      endcase
      res.crow = ROW_W'(row_model);
      res.ccol = COL_W'(col_model);
      return res;
   endfunction

   function automatic console_req_type make_word(req_code_type kind, logic [CHAR_W-1:0] ch,
                                                 logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
      console_req_type w;
      w.kind      = kind;
      w.char_code = ch;
      w.row       = r;
      w.col       = c;
      return w;
   endfunction

   // mostly on-screen positions, now and then past the edge to hit saturation
   function automatic logic [ROW_W-1:0] any_row();
      return ($urandom_range(4) == 0) ? ROW_W'($urandom_range(31)) : ROW_W'($urandom_range(24));
   endfunction

   function automatic logic [COL_W-1:0] any_col();
      return ($urandom_range(4) == 0) ? COL_W'($urandom_range(127)) : COL_W'($urandom_range(79));
   endfunction

   function automatic console_req_type put_word(logic [CHAR_W-1:0] ch);
      return make_word(REQ_PUT_CHAR, ch, ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
   endfunction

   task automatic flag_error(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR: %s", msg);
   endtask

   // driver: hold a word until taken, then maybe idle, then offer the next
   always @(posedge clock) begin
      console_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_rsps.push_back(console_apply(cur_req));
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               cur_req   <= nxt;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each taken response word, then choose next stall
   always @(posedge clock) begin
      console_rsp_type got;
      console_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_cell_data, rsp_cursor_row, rsp_cursor_col, rsp_scrolled};
            if (expected_rsps.size() == 0) begin
               flag_error($sformatf("unexpected response cell=%h row=%0d col=%0d scrolled=%0b",
                                    got.cell_val, got.crow, got.ccol, got.scrolled));
            end else begin
               want = expected_rsps.pop_front();
               if (got.cell_val !== want.cell_val || got.crow !== want.crow ||
                   got.ccol !== want.ccol || got.scrolled !== want.scrolled)
                  flag_error($sformatf(
                     "cell %h/%h row %0d/%0d col %0d/%0d scrolled %0b/%0b (exp/act)",
                     want.cell_val, got.cell_val, want.crow, got.crow, want.ccol, got.ccol,
                     want.scrolled, got.scrolled));
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_seen != hold_trig) begin
            hold_seen <= hold_trig;
            hold_left <= LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog on words moving through either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // wait for every response, then for any blanking walk to finish
   task automatic drain_console();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (WALK_WAIT) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      attr_model = value;
   endtask

   task automatic queue_random_words(input int unsigned total);
      int unsigned made;
      int unsigned pick;
      int unsigned len;
      logic [CHAR_W-1:0] ctl;
      made = 0;
      while (made < total) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            // a line of text, sometimes typed on the last row to force scrolls
            if ($urandom_range(2) == 0) begin
               pending_reqs.push_back(make_word(REQ_SET_CURSOR, CHAR_W'($urandom_range(255)),
                                                ROW_W'(ROWS - 1), any_col()));
               made++;
            end
            len = $urandom_range(24, 4);
            repeat (len) begin
               pending_reqs.push_back(put_word(CHAR_W'($urandom_range(126, 32))));
               made++;
            end
            if ($urandom_range(1) == 0) begin
               pending_reqs.push_back(put_word(CH_NEWLINE));
               made++;
            end
         end else if (pick < 45) begin
            pending_reqs.push_back(put_word(CHAR_W'($urandom_range(255))));
            made++;
         end else if (pick < 55) begin
            case ($urandom_range(3))
               0: ctl = CH_NEWLINE;
               1: ctl = CH_RETURN;
               2: ctl = CH_BACKSPACE;
               default: ctl = CH_TAB;
            endcase
            pending_reqs.push_back(put_word(ctl));
            made++;
         end else if (pick < 76) begin
            pending_reqs.push_back(make_word(REQ_READ_CELL, CHAR_W'($urandom_range(255)),
                                             any_row(), any_col()));
            made++;
         end else if (pick < 98) begin
            pending_reqs.push_back(make_word(REQ_SET_CURSOR, CHAR_W'($urandom_range(255)),
                                             any_row(), any_col()));
            made++;
         end else begin
            pending_reqs.push_back(make_word(REQ_CLEAR, CHAR_W'($urandom_range(255)),
                                             ROW_W'($urandom_range(31)),
                                             COL_W'($urandom_range(127))));
            made++;
         end
      end
   endtask

   initial begin
      attr_model = ATTR_RESET;
      blank_screen();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: blanks after reset, saturation, control characters, wrap and scroll
      pending_reqs.push_back(make_word(REQ_READ_CELL,  8'h00, 5'd0,  7'd0));
      pending_reqs.push_back(make_word(REQ_READ_CELL,  8'hFF, 5'd31, 7'd127));
      pending_reqs.push_back(put_word(8'h41));
      pending_reqs.push_back(put_word(8'h00));
      pending_reqs.push_back(put_word(8'hFF));
      pending_reqs.push_back(put_word(CH_BACKSPACE));
      pending_reqs.push_back(put_word(CH_TAB));
      pending_reqs.push_back(put_word(CH_RETURN));
      pending_reqs.push_back(make_word(REQ_READ_CELL,  8'h00, 5'd0,  7'd0));
      pending_reqs.push_back(make_word(REQ_READ_CELL,  8'h00, 5'd0,  7'd2));
      pending_reqs.push_back(put_word(CH_BACKSPACE));
      pending_reqs.push_back(make_word(REQ_SET_CURSOR, 8'h00, 5'd31, 7'd127));
      pending_reqs.push_back(put_word(8'h5A));
      pending_reqs.push_back(make_word(REQ_READ_CELL,  8'h00, 5'd23, 7'd79));
      pending_reqs.push_back(make_word(REQ_SET_CURSOR, 8'h00, 5'd10, 7'd76));
      pending_reqs.push_back(put_word(CH_TAB));
      pending_reqs.push_back(make_word(REQ_SET_CURSOR, 8'h00, 5'd24, 7'd75));
      pending_reqs.push_back(put_word(CH_TAB));
      pending_reqs.push_back(put_word(CH_NEWLINE));
      pending_reqs.push_back(make_word(REQ_READ_CELL,  8'h00, 5'd21, 7'd79));
      pending_reqs.push_back(make_word(REQ_SET_CURSOR, 8'h00, 5'd0,  7'd0));
      pending_reqs.push_back(make_word(REQ_CLEAR,      8'h00, 5'd0,  7'd0));
      pending_reqs.push_back(make_word(REQ_READ_CELL,  8'h00, 5'd5,  7'd5));
      pending_reqs.push_back(make_word(REQ_SET_CURSOR, 8'h00, 5'd3,  7'd40));
      pending_reqs.push_back(put_word(CH_NEWLINE));
      drain_console();

      write_attribute(8'h00);
      queue_random_words(PHASE_WORDS);
      drain_console();

      write_attribute(8'hFF);
      send_idle_pct = 69;
      recv_idle_pct = 24;
      queue_random_words(PHASE_WORDS);
      drain_console();

      write_attribute(ATTR_W'($urandom_range(255)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_words(PHASE_WORDS);
      // back-pressure the response side while the driver keeps offering
      hold_trig++;
      drain_console();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/tccw_pkg.sv
design/tccw_ram.sv
design/text_console_cursor_writer.sv
test/tb_text_console_cursor_writer.sv
